// File: sv/psg_tone_noise_generator_unit_assert.svh
// Assertion macros shared by the noise channel and the top-level generator module.
`ifndef PSG_TONE_NOISE_GENERATOR_UNIT_ASSERT_SVH
`define PSG_TONE_NOISE_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define PSG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psg assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define PSG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psg assertion failed");

`endif

// File: sv/psg_pkg.sv
// Types, constants and the volume table of the tone and noise generator.
package psg_pkg;

    // Widths of the data path
    localparam int PERIOD_W    = 10;
    localparam int VOL_W       = 7;
    localparam int TONE_LVL_W  = 8;
    localparam int NOISE_LVL_W = 9;
    localparam int NOISE_SUM_W = 10;
    localparam int MIX_W       = 10;

    // Noise shift register
    localparam int SHIFTER_WIDTH = 16;
    localparam logic [SHIFTER_WIDTH-1:0] SHIFTER_RESET = {1'b1, {(SHIFTER_WIDTH-1){1'b0}}};

    // Operation codes
    localparam logic [1:0] OP_CHIP_WRITE = 2'd0;
    localparam logic [1:0] OP_ROUTING    = 2'd1;
    localparam logic [1:0] OP_TICK       = 2'd2;

    // Latched register codes (odd codes are volumes)
    localparam logic [2:0] REG_TONE0 = 3'd0;
    localparam logic [2:0] REG_TONE1 = 3'd2;
    localparam logic [2:0] REG_TONE2 = 3'd4;
    localparam logic [2:0] REG_NOISE = 3'd6;

    // Noise control and timing
    localparam logic [7:0] NOISE_PERIOD_RESET = 8'h10;
    localparam logic [7:0] NOISE_TRACK_TONE2  = 8'h80;
    localparam int         NOISE_WHITE_BIT    = 2;
    localparam logic [7:0] ROUTING_RESET      = 8'hff;

    // Tone periods above 1 and up to this value toggle the phase without sound
    localparam logic [PERIOD_W-1:0] SILENT_MAX = 10'd10;

    // Noise level saturation bounds
    localparam logic signed [NOISE_SUM_W-1:0] NOISE_SAT_HI = 10'sd128;
    localparam logic signed [NOISE_SUM_W-1:0] NOISE_SAT_LO = -10'sd128;

    // Noise channel settings handed from the register file
    typedef struct packed {
        logic [3:0]       control;
        logic [7:0]       period;
        logic [VOL_W-1:0] volume;
    } noise_cfg_t;

    // Attenuation to amplitude
    function automatic logic [VOL_W-1:0] vol_lookup(input logic [3:0] atten);
        logic [VOL_W-1:0] v;
        case (atten)
            4'd0:    v = 7'd64;
            4'd1:    v = 7'd50;
            4'd2:    v = 7'd39;
            4'd3:    v = 7'd31;
            4'd4:    v = 7'd24;
            4'd5:    v = 7'd19;
            4'd6:    v = 7'd15;
            4'd7:    v = 7'd12;
            4'd8:    v = 7'd9;
            4'd9:    v = 7'd7;
            4'd10:   v = 7'd5;
            4'd11:   v = 7'd4;
            4'd12:   v = 7'd3;
            4'd13:   v = 7'd2;
            4'd14:   v = 7'd1;
            default: v = 7'd0;
        endcase
        return v;
    endfunction

endpackage

// File: sv/psg_req_if.sv
// Request channel: operation code and data byte with valid/ready handshake.
interface psg_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink (input valid, input operation, input data_byte, output ready);
endinterface

// File: sv/psg_res_if.sv
// Result channel: channel levels and stereo mixes with valid/ready handshake.
interface psg_res_if;
    logic              valid;
    logic              ready;
    logic signed [9:0] left_mix;
    logic signed [9:0] right_mix;
    logic signed [7:0] tone0_level;
    logic signed [7:0] tone1_level;
    logic signed [7:0] tone2_level;
    logic signed [8:0] noise_level;

    modport source (output valid, output left_mix, output right_mix, output tone0_level,
                    output tone1_level, output tone2_level, output noise_level,
                    input ready);
    modport sink (input valid, input left_mix, input right_mix, input tone0_level,
                  input tone1_level, input tone2_level, input noise_level,
                  output ready);
endinterface

// File: sv/psg_tone_channel.sv
// One square-tone channel: down counter, phase and held level.
module psg_tone_channel
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       tick_en,
    input  logic [psg_pkg::PERIOD_W-1:0]               period,
    input  logic [psg_pkg::VOL_W-1:0]                  volume,
    output logic [psg_pkg::PERIOD_W-1:0]               counter,
    output logic signed [psg_pkg::TONE_LVL_W-1:0]      level_next
);

    logic [psg_pkg::PERIOD_W-1:0]          counter_reg, counter_next;
    logic                                  phase_reg, phase_next;
    logic signed [psg_pkg::TONE_LVL_W-1:0] level_reg;
    logic signed [psg_pkg::TONE_LVL_W-1:0] vol_s;

    assign vol_s   = {1'b0, volume};
    assign counter = counter_reg;

    // Count down; on expiry reload and move the phase
    always_comb
    begin
        counter_next = counter_reg;
        phase_next   = phase_reg;
        level_next   = level_reg;
        if (tick_en)
        begin
            if (counter_reg <= 10'd1)
            begin
                counter_next = period;
                if (period > psg_pkg::SILENT_MAX)
                begin
                    phase_next = ~phase_reg;
                    level_next = phase_next ? vol_s : -vol_s;
                end
                else if (period <= 10'd1)
                begin
                    // very short periods hold the output high
                    phase_next = 1'b1;
                    level_next = vol_s;
                end
                else
                begin
                    // inaudible range: phase runs, level is kept
                    phase_next = ~phase_reg;
                end
            end
            else
            begin
                counter_next = counter_reg - 10'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            phase_reg   <= 1'b1;
            level_reg   <= '0;
        end
        else
        begin
            counter_reg <= counter_next;
            phase_reg   <= phase_next;
            level_reg   <= level_next;
        end
    end

endmodule

// File: sv/psg_noise_channel.sv
// Noise channel: rate counter, LFSR and saturating accumulated level.
module psg_noise_channel
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   tick_en,
    input  logic                                   reload,
    input  psg_pkg::noise_cfg_t                    cfg,
    input  logic [psg_pkg::PERIOD_W-1:0]           tone2_counter,
    input  logic [psg_pkg::PERIOD_W-1:0]           tone2_period,
    output logic signed [psg_pkg::NOISE_LVL_W-1:0] level_next
);

`include "psg_tone_noise_generator_unit_assert.svh"

    logic [psg_pkg::PERIOD_W-1:0]           counter_reg, counter_next;
    logic                                   phase_reg, phase_next;
    logic [psg_pkg::SHIFTER_WIDTH-1:0]      shifter_reg, shifter_next;
    logic signed [psg_pkg::NOISE_LVL_W-1:0] level_reg;

    logic                                   track;
    logic [psg_pkg::PERIOD_W-1:0]           cnt_now;
    logic [psg_pkg::PERIOD_W-1:0]           reload_val;
    logic                                   fb;
    logic signed [psg_pkg::NOISE_SUM_W-1:0] vol_s;
    logic signed [psg_pkg::NOISE_SUM_W-1:0] sum;

    // Rate source: own period, or follow tone 2's counter and period
    assign track      = (cfg.period == psg_pkg::NOISE_TRACK_TONE2);
    assign cnt_now    = track ? tone2_counter : counter_reg;
    assign reload_val = track ? tone2_period : {2'b00, cfg.period};

    // Feedback: white taps bits 0 and 3, periodic recirculates bit 0
    assign fb    = cfg.control[psg_pkg::NOISE_WHITE_BIT] ? (shifter_reg[0] ^ shifter_reg[3])
                                                         : shifter_reg[0];
    assign vol_s = {3'b000, cfg.volume};

    // Level moves by the change of the output bit, scaled by volume
    always_comb
    begin
        sum = {level_reg[psg_pkg::NOISE_LVL_W-1], level_reg};
        if (shifter_reg[1])
            sum = sum + vol_s;
        if (shifter_reg[0])
            sum = sum - vol_s;
    end

    always_comb
    begin
        counter_next = counter_reg;
        phase_next   = phase_reg;
        shifter_next = shifter_reg;
        level_next   = level_reg;
        if (reload)
        begin
            shifter_next = psg_pkg::SHIFTER_RESET;
        end
        else if (tick_en)
        begin
            if (cnt_now <= 10'd1)
            begin
                counter_next = reload_val;
                phase_next   = ~phase_reg;
                // shift on every second expiry
                if (phase_next)
                begin
                    shifter_next = {fb, shifter_reg[psg_pkg::SHIFTER_WIDTH-1:1]};
                    if (sum > psg_pkg::NOISE_SAT_HI)
                        level_next = psg_pkg::NOISE_SAT_HI[psg_pkg::NOISE_LVL_W-1:0];
                    else if (sum < psg_pkg::NOISE_SAT_LO)
                        level_next = psg_pkg::NOISE_SAT_LO[psg_pkg::NOISE_LVL_W-1:0];
                    else
                        level_next = sum[psg_pkg::NOISE_LVL_W-1:0];
                end
            end
            else
            begin
                counter_next = cnt_now - 10'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            phase_reg   <= 1'b1;
            shifter_reg <= psg_pkg::SHIFTER_RESET;
            level_reg   <= '0;
        end
        else
        begin
            counter_reg <= counter_next;
            phase_reg   <= phase_next;
            shifter_reg <= shifter_next;
            level_reg   <= level_next;
        end
    end

    // Checks
    `PSG_ASSERT_IMPL(a_noise_range, 1'b1, (level_reg >= -9'sd128) && (level_reg <= 9'sd128))
    `PSG_ASSERT_NEXT(a_level_hold, !tick_en, $stable(level_reg))
    `PSG_ASSERT_NEXT(a_shifter_hold, !tick_en && !reload, $stable(shifter_reg))

endmodule

// File: sv/psg_tone_noise_generator_unit.sv
// Top level of the tone and noise generator: register file, channels, mixer.
// The block takes one item per clock cycle while no tick waits in the input
// register for the output. An item is captured in an input register, and
// when it advances a single update stage applies it to the chip registers
// and channel counters; an advancing tick writes its result into the output
// register, from which it is offered. Chip and routing writes give no
// result. A result that waits to be taken stalls only further ticks:
// writes behind it still flow through the input register, but a tick that
// reaches the input register waits there and holds off the input until the
// waiting result is taken.
module psg_tone_noise_generator_unit
(
    input  logic      clk,
    input  logic      rst_n,
    psg_req_if.sink   request,
    psg_res_if.source result,
    input  logic      cfg_we,
    input  logic      cfg_wdata
);

`include "psg_tone_noise_generator_unit_assert.svh"

    // Input register
    logic       s1_valid_reg, s1_valid_next;
    logic [1:0] s1_op_reg;
    logic [7:0] s1_data_reg;
    logic       s1_adv;
    logic       req_fire;

    // Chip registers
    logic                          stereo_mode_reg;
    logic [2:0]                    latched_reg, latched_next;
    logic [psg_pkg::PERIOD_W-1:0]  tone_period_reg [3];
    logic [psg_pkg::PERIOD_W-1:0]  tone_period_next [3];
    logic [3:0]                    noise_control_reg, noise_control_next;
    logic [7:0]                    noise_period_reg, noise_period_next;
    logic [psg_pkg::VOL_W-1:0]     volume_reg [4];
    logic [psg_pkg::VOL_W-1:0]     volume_next [4];
    logic [7:0]                    routing_reg, routing_next;
    logic                          noise_reload;
    logic [2:0]                    latch_now;

    // Channels
    logic                                   tick_fire;
    logic [psg_pkg::PERIOD_W-1:0]           tone_counter [3];
    logic signed [psg_pkg::TONE_LVL_W-1:0]  tone_level [3];
    logic signed [psg_pkg::NOISE_LVL_W-1:0] noise_level;
    psg_pkg::noise_cfg_t                    noise_cfg;

    // Mixer and output register
    logic signed [psg_pkg::MIX_W-1:0] lvl_ext [4];
    logic signed [psg_pkg::MIX_W-1:0] left_sum, right_sum;
    logic                             out_valid_reg, out_valid_next;
    logic signed [psg_pkg::MIX_W-1:0] left_reg, right_reg;
    logic signed [7:0]                tone0_reg, tone1_reg, tone2_reg;
    logic signed [8:0]                noise_reg;

    // Handshake: a tick advances only when the output register is free
    assign s1_adv        = s1_valid_reg && ((s1_op_reg != psg_pkg::OP_TICK) ||
                                            !out_valid_reg || result.ready);
    assign request.ready = !s1_valid_reg || s1_adv;
    assign req_fire      = request.valid && request.ready;
    assign s1_valid_next = req_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign tick_fire     = s1_adv && (s1_op_reg == psg_pkg::OP_TICK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_op_reg   <= request.operation;
            s1_data_reg <= request.data_byte;
        end
    end

    // Chip and routing writes
    assign latch_now = s1_data_reg[7] ? s1_data_reg[6:4] : latched_reg;

    always_comb
    begin
        latched_next       = latched_reg;
        tone_period_next   = tone_period_reg;
        noise_control_next = noise_control_reg;
        noise_period_next  = noise_period_reg;
        volume_next        = volume_reg;
        routing_next       = routing_reg;
        noise_reload       = 1'b0;
        if (s1_adv && (s1_op_reg == psg_pkg::OP_ROUTING))
        begin
            routing_next = s1_data_reg;
        end
        if (s1_adv && (s1_op_reg == psg_pkg::OP_CHIP_WRITE))
        begin
            latched_next = latch_now;
            case (latch_now)
                psg_pkg::REG_TONE0, psg_pkg::REG_TONE1, psg_pkg::REG_TONE2:
                begin
                    if (s1_data_reg[7])
                        tone_period_next[latch_now[2:1]][3:0] = s1_data_reg[3:0];
                    else
                        tone_period_next[latch_now[2:1]][9:4] = s1_data_reg[5:0];
                end
                psg_pkg::REG_NOISE:
                begin
                    noise_control_next = s1_data_reg[3:0];
                    noise_period_next  = psg_pkg::NOISE_PERIOD_RESET << s1_data_reg[1:0];
                    noise_reload       = 1'b1;
                end
                default:
                begin
                    volume_next[latch_now[2:1]] = psg_pkg::vol_lookup(s1_data_reg[3:0]);
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stereo_mode_reg   <= 1'b0;
            latched_reg       <= '0;
            noise_control_reg <= '0;
            noise_period_reg  <= psg_pkg::NOISE_PERIOD_RESET;
            routing_reg       <= psg_pkg::ROUTING_RESET;
            for (int i = 0; i < 3; i++)
                tone_period_reg[i] <= '0;
            for (int i = 0; i < 4; i++)
                volume_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
                stereo_mode_reg <= cfg_wdata;
            latched_reg       <= latched_next;
            noise_control_reg <= noise_control_next;
            noise_period_reg  <= noise_period_next;
            routing_reg       <= routing_next;
            tone_period_reg   <= tone_period_next;
            volume_reg        <= volume_next;
        end
    end

    // Tone channels
    for (genvar c = 0; c < 3; c++)
    begin : g_tone
        psg_tone_channel u_tone
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .tick_en    (tick_fire),
            .period     (tone_period_reg[c]),
            .volume     (volume_reg[c]),
            .counter    (tone_counter[c]),
            .level_next (tone_level[c])
        );
    end

    // Noise channel, updated ahead of the tones within a tick
    assign noise_cfg.control = noise_control_reg;
    assign noise_cfg.period  = noise_period_reg;
    assign noise_cfg.volume  = volume_reg[3];

    psg_noise_channel u_noise
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick_en       (tick_fire),
        .reload        (noise_reload),
        .cfg           (noise_cfg),
        .tone2_counter (tone_counter[2]),
        .tone2_period  (tone_period_reg[2]),
        .level_next    (noise_level)
    );

    // Stereo mixer over the updated levels
    assign lvl_ext[0] = {{2{tone_level[0][7]}}, tone_level[0]};
    assign lvl_ext[1] = {{2{tone_level[1][7]}}, tone_level[1]};
    assign lvl_ext[2] = {{2{tone_level[2][7]}}, tone_level[2]};
    assign lvl_ext[3] = {noise_level[8], noise_level};

    always_comb
    begin
        left_sum  = '0;
        right_sum = '0;
        for (int c = 0; c < 4; c++)
        begin
            if (!stereo_mode_reg || routing_reg[4+c])
                left_sum = left_sum + lvl_ext[c];
            if (!stereo_mode_reg || routing_reg[c])
                right_sum = right_sum + lvl_ext[c];
        end
    end

    // Output register
    assign out_valid_next = tick_fire || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            left_reg  <= left_sum;
            right_reg <= right_sum;
            tone0_reg <= tone_level[0];
            tone1_reg <= tone_level[1];
            tone2_reg <= tone_level[2];
            noise_reg <= noise_level;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.left_mix    = left_reg;
    assign result.right_mix   = right_reg;
    assign result.tone0_level = tone0_reg;
    assign result.tone1_level = tone1_reg;
    assign result.tone2_level = tone2_reg;
    assign result.noise_level = noise_reg;

    // Checks
    `PSG_ASSERT_NEXT(a_tick_result, tick_fire, out_valid_reg)
    `PSG_ASSERT_IMPL(a_no_overwrite, out_valid_reg && !result.ready, !tick_fire)
    `PSG_ASSERT_NEXT(a_mono_equal, tick_fire && !stereo_mode_reg, left_reg == right_reg)

endmodule
